### hw/rtl/motor_point_transform_core_macros.svh
// ---------------------------------------------------------------------------
// motor point transform assertion macros
// immediate-style wrappers around concurrent checks on clk / arst_n
// ---------------------------------------------------------------------------
`ifndef MOTOR_POINT_TRANSFORM_CORE_MACROS_SVH
`define MOTOR_POINT_TRANSFORM_CORE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define MPT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define MPT_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define MPT_ASSERT_IMP(lbl, ante, cons, msg)
`define MPT_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

### hw/rtl/mpt_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mpt_pkg
// shared types, register map and fixed point helpers for the point transform
// ---------------------------------------------------------------------------
package mpt_pkg;

	// rotor fraction bits, every product is floored by this amount
	localparam int ROT_FRAC = 30;
	localparam int ADDR_W   = 5;

	typedef logic signed [31:0] word_t;
	// floored product of two words
	typedef logic signed [33:0] prod_t;
	// wide accumulator for sums and the final result
	typedef logic signed [38:0] wide_t;

	localparam word_t ROTOR_ONE = word_t'(64'sd1 <<< ROT_FRAC);

	typedef enum logic [2:0] {
		REG_ROTOR_X = 3'd0,
		REG_ROTOR_Y = 3'd1,
		REG_ROTOR_Z = 3'd2,
		REG_ROTOR_W = 3'd3,
		REG_SCREW_X = 3'd4,
		REG_SCREW_Y = 3'd5,
		REG_SCREW_Z = 3'd6,
		REG_SCREW_W = 3'd7
	} reg_idx_t;

	typedef struct packed {
		word_t rx;
		word_t ry;
		word_t rz;
		word_t rw;
		word_t ux;
		word_t uy;
		word_t uz;
		word_t uw;
	} cfg_t;

	// word handed from the front half to the back half of the pipeline
	typedef struct packed {
		logic  valid;
		logic  flag;
		word_t px;
		word_t py;
		word_t pz;
		word_t vx;
		word_t vy;
		word_t vz;
		word_t rxry;
		word_t ryrz;
		word_t rzrx;
		word_t syz;
		word_t szx;
		word_t sxy;
		wide_t lin_x;
		wide_t lin_y;
		wide_t lin_z;
	} prep_t;

	// full 64-bit product, floored by the rotor fraction
	function automatic prod_t mulr(word_t a, word_t b);
		logic signed [63:0] p;
		p = a * b;
		return prod_t'(p >>> ROT_FRAC);
	endfunction

	// true when the value does not fit a signed word
	function automatic logic ovf32(wide_t x);
		return !((&x[38:31]) || (~|x[38:31]));
	endfunction

	// clamp to a signed word
	function automatic word_t sat32(wide_t x);
		word_t r;
		if (ovf32(x)) begin
			r = x[38] ? word_t'(32'h8000_0000) : word_t'(32'h7fff_ffff);
		end else begin
			r = word_t'(x[31:0]);
		end
		return r;
	endfunction

endpackage

### hw/rtl/mpt_regs.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mpt_regs
// apb register file holding the rotor and screw of the motor
// ---------------------------------------------------------------------------
`include "motor_point_transform_core_macros.svh"
module mpt_regs (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [mpt_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready,
	output mpt_pkg::cfg_t             cfg
);
	import mpt_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	// register writes, reset loads the identity motor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{rx: '0, ry: '0, rz: '0, rw: ROTOR_ONE,
				ux: '0, uy: '0, uz: '0, uw: '0};
		end else if (wr_en) begin
			unique case (idx)
				REG_ROTOR_X: cfg_q.rx <= word_t'(pwdata);
				REG_ROTOR_Y: cfg_q.ry <= word_t'(pwdata);
				REG_ROTOR_Z: cfg_q.rz <= word_t'(pwdata);
				REG_ROTOR_W: cfg_q.rw <= word_t'(pwdata);
				REG_SCREW_X: cfg_q.ux <= word_t'(pwdata);
				REG_SCREW_Y: cfg_q.uy <= word_t'(pwdata);
				REG_SCREW_Z: cfg_q.uz <= word_t'(pwdata);
				REG_SCREW_W: cfg_q.uw <= word_t'(pwdata);
				default:     cfg_q    <= cfg_q;
			endcase
		end
	end

	// read back
	always_comb begin
		unique case (idx)
			REG_ROTOR_X: prdata = cfg_q.rx;
			REG_ROTOR_Y: prdata = cfg_q.ry;
			REG_ROTOR_Z: prdata = cfg_q.rz;
			REG_ROTOR_W: prdata = cfg_q.rw;
			REG_SCREW_X: prdata = cfg_q.ux;
			REG_SCREW_Y: prdata = cfg_q.uy;
			REG_SCREW_Z: prdata = cfg_q.uz;
			REG_SCREW_W: prdata = cfg_q.uw;
			default:     prdata = '0;
		endcase
	end

	`MPT_ASSERT_NXT(a_rw_written, wr_en && (idx == REG_ROTOR_W), cfg_q.rw == $past(pwdata), "rotor w write lost")
	`MPT_ASSERT_NXT(a_cfg_hold, !wr_en, $stable(cfg_q), "config changed without a write")

endmodule

### hw/rtl/mpt_prep.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mpt_prep
// stages 1-2: rotor products, screw terms and the shifted point v
// ---------------------------------------------------------------------------
module mpt_prep (
	input  logic           clk,
	input  logic           arst_n,
	input  mpt_pkg::cfg_t  cfg,
	input  logic           in_valid,
	input  mpt_pkg::word_t px,
	input  mpt_pkg::word_t py,
	input  mpt_pkg::word_t pz,
	output mpt_pkg::prep_t prep
);
	import mpt_pkg::*;

	logic  valid_s1;
	word_t px_s1, py_s1, pz_s1;
	prod_t rx2_s1, ry2_s1, rz2_s1, ryrz_s1, rzrx_s1, rxry_s1;
	prod_t pxrw_s1, pyrw_s1, pzrw_s1;
	prod_t uxrw_s1, uyrw_s1, uzrw_s1, rxuw_s1, ryuw_s1, rzuw_s1;

	word_t rx2, ry2, rz2;
	wide_t syz_w, szx_w, sxy_w, vx_w, vy_w, vz_w;
	logic  rot_ovf, sum_ovf, v_ovf;
	prep_t prep_s2;

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	// stage 1: all products that need only config and the point
	always_ff @(posedge clk) begin
		px_s1   <= px;
		py_s1   <= py;
		pz_s1   <= pz;
		rx2_s1  <= mulr(cfg.rx, cfg.rx);
		ry2_s1  <= mulr(cfg.ry, cfg.ry);
		rz2_s1  <= mulr(cfg.rz, cfg.rz);
		ryrz_s1 <= mulr(cfg.ry, cfg.rz);
		rzrx_s1 <= mulr(cfg.rz, cfg.rx);
		rxry_s1 <= mulr(cfg.rx, cfg.ry);
		pxrw_s1 <= mulr(px, cfg.rw);
		pyrw_s1 <= mulr(py, cfg.rw);
		pzrw_s1 <= mulr(pz, cfg.rw);
		uxrw_s1 <= mulr(cfg.ux, cfg.rw);
		uyrw_s1 <= mulr(cfg.uy, cfg.rw);
		uzrw_s1 <= mulr(cfg.uz, cfg.rw);
		rxuw_s1 <= mulr(cfg.rx, cfg.uw);
		ryuw_s1 <= mulr(cfg.ry, cfg.uw);
		rzuw_s1 <= mulr(cfg.rz, cfg.uw);
	end

	// saturate squares, then sums of two squares and v
	always_comb begin
		rx2     = sat32(wide_t'(rx2_s1));
		ry2     = sat32(wide_t'(ry2_s1));
		rz2     = sat32(wide_t'(rz2_s1));
		syz_w   = wide_t'(ry2) + wide_t'(rz2);
		szx_w   = wide_t'(rz2) + wide_t'(rx2);
		sxy_w   = wide_t'(rx2) + wide_t'(ry2);
		vx_w    = wide_t'(cfg.ux) + wide_t'(pxrw_s1);
		vy_w    = wide_t'(cfg.uy) + wide_t'(pyrw_s1);
		vz_w    = wide_t'(cfg.uz) + wide_t'(pzrw_s1);
		rot_ovf = ovf32(wide_t'(rx2_s1)) || ovf32(wide_t'(ry2_s1))
			|| ovf32(wide_t'(rz2_s1)) || ovf32(wide_t'(ryrz_s1))
			|| ovf32(wide_t'(rzrx_s1)) || ovf32(wide_t'(rxry_s1));
		sum_ovf = ovf32(syz_w) || ovf32(szx_w) || ovf32(sxy_w);
		v_ovf   = ovf32(vx_w) || ovf32(vy_w) || ovf32(vz_w);
	end

	// stage 2 valid and payload, both cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prep_s2 <= '0;
		end else begin
			prep_s2.valid <= valid_s1;
			prep_s2.flag  <= rot_ovf || sum_ovf || v_ovf;
			prep_s2.px    <= px_s1;
			prep_s2.py    <= py_s1;
			prep_s2.pz    <= pz_s1;
			prep_s2.vx    <= sat32(vx_w);
			prep_s2.vy    <= sat32(vy_w);
			prep_s2.vz    <= sat32(vz_w);
			prep_s2.rxry  <= sat32(wide_t'(rxry_s1));
			prep_s2.ryrz  <= sat32(wide_t'(ryrz_s1));
			prep_s2.rzrx  <= sat32(wide_t'(rzrx_s1));
			prep_s2.syz   <= sat32(syz_w);
			prep_s2.szx   <= sat32(szx_w);
			prep_s2.sxy   <= sat32(sxy_w);
			prep_s2.lin_x <= wide_t'(uxrw_s1) - wide_t'(rxuw_s1);
			prep_s2.lin_y <= wide_t'(uyrw_s1) - wide_t'(ryuw_s1);
			prep_s2.lin_z <= wide_t'(uzrw_s1) - wide_t'(rzuw_s1);
		end
	end

	assign prep = prep_s2;

endmodule

### hw/rtl/mpt_mix.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mpt_mix
// stages 3-5: cross and square terms, bracket sum, doubling and saturation
// ---------------------------------------------------------------------------
module mpt_mix (
	input  logic           clk,
	input  logic           arst_n,
	input  mpt_pkg::cfg_t  cfg,
	input  mpt_pkg::prep_t prep,
	output logic           done,
	output mpt_pkg::word_t moved_x,
	output mpt_pkg::word_t moved_y,
	output mpt_pkg::word_t moved_z,
	output logic           overflow
);
	import mpt_pkg::*;

	logic  valid_s3, valid_s4, valid_s5;
	logic  flag_s3, flag_s4;
	word_t px_s3, py_s3, pz_s3, px_s4, py_s4, pz_s4;
	wide_t lin_x_s3, lin_y_s3, lin_z_s3;
	// per axis: two cross terms, two mixed terms, one square term
	prod_t xa_s3, xb_s3, xc_s3, xd_s3, xe_s3;
	prod_t ya_s3, yb_s3, yc_s3, yd_s3, ye_s3;
	prod_t za_s3, zb_s3, zc_s3, zd_s3, ze_s3;
	wide_t bx_s4, by_s4, bz_s4;
	wide_t mx_w, my_w, mz_w;
	word_t mx_s5, my_s5, mz_s5;
	logic  ovf_s5;

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s3 <= prep.valid;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	// stage 3: products with v and the rotor terms
	always_ff @(posedge clk) begin
		flag_s3  <= prep.flag;
		px_s3    <= prep.px;
		py_s3    <= prep.py;
		pz_s3    <= prep.pz;
		lin_x_s3 <= prep.lin_x;
		lin_y_s3 <= prep.lin_y;
		lin_z_s3 <= prep.lin_z;
		xa_s3    <= mulr(cfg.ry, prep.vz);
		xb_s3    <= mulr(cfg.rz, prep.vy);
		xc_s3    <= mulr(prep.py, prep.rxry);
		xd_s3    <= mulr(prep.pz, prep.rzrx);
		xe_s3    <= mulr(prep.px, prep.syz);
		ya_s3    <= mulr(cfg.rz, prep.vx);
		yb_s3    <= mulr(cfg.rx, prep.vz);
		yc_s3    <= mulr(prep.px, prep.rxry);
		yd_s3    <= mulr(prep.pz, prep.ryrz);
		ye_s3    <= mulr(prep.py, prep.szx);
		za_s3    <= mulr(cfg.rx, prep.vy);
		zb_s3    <= mulr(cfg.ry, prep.vx);
		zc_s3    <= mulr(prep.px, prep.rzrx);
		zd_s3    <= mulr(prep.py, prep.ryrz);
		ze_s3    <= mulr(prep.pz, prep.sxy);
	end

	// stage 4: bracket sum per axis
	always_ff @(posedge clk) begin
		flag_s4 <= flag_s3;
		px_s4   <= px_s3;
		py_s4   <= py_s3;
		pz_s4   <= pz_s3;
		bx_s4   <= lin_x_s3 + wide_t'(xa_s3) - wide_t'(xb_s3) + wide_t'(xc_s3)
			+ wide_t'(xd_s3) - wide_t'(xe_s3);
		by_s4   <= lin_y_s3 + wide_t'(ya_s3) - wide_t'(yb_s3) + wide_t'(yc_s3)
			+ wide_t'(yd_s3) - wide_t'(ye_s3);
		bz_s4   <= lin_z_s3 + wide_t'(za_s3) - wide_t'(zb_s3) + wide_t'(zc_s3)
			+ wide_t'(zd_s3) - wide_t'(ze_s3);
	end

	// p + 2b before clamping
	always_comb begin
		mx_w = wide_t'(px_s4) + (bx_s4 <<< 1);
		my_w = wide_t'(py_s4) + (by_s4 <<< 1);
		mz_w = wide_t'(pz_s4) + (bz_s4 <<< 1);
	end

	// stage 5: saturate into the output register
	always_ff @(posedge clk) begin
		mx_s5  <= sat32(mx_w);
		my_s5  <= sat32(my_w);
		mz_s5  <= sat32(mz_w);
		ovf_s5 <= flag_s4 || ovf32(mx_w) || ovf32(my_w) || ovf32(mz_w);
	end

	assign done     = valid_s5;
	assign moved_x  = mx_s5;
	assign moved_y  = my_s5;
	assign moved_z  = mz_s5;
	assign overflow = ovf_s5;

endmodule

### hw/rtl/motor_point_transform_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// motor_point_transform_core
// applies a rigid motion (rotor and screw) to a stream of fixed point points
// ---------------------------------------------------------------------------
//  channel   handshake                     payload
//  point in  start (accepted, busy low)    point_x, point_y, point_z
//  result    done strobe, one cycle        moved_x, moved_y, moved_z, overflow
//  config    apb write, pready tied high   paddr, pwdata / prdata
//
//  one point per cycle, done rises together with the result word
//  at the output of the last stage
//  five register stages: products, squares and v, v products, bracket sum, clamp
//  busy stays low: the pipeline never stalls and the receiver cannot stall
//  arst_n clears the valid chain and loads the identity motor
// ---------------------------------------------------------------------------
`include "motor_point_transform_core_macros.svh"
module motor_point_transform_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  mpt_pkg::word_t             point_x,
	input  mpt_pkg::word_t             point_y,
	input  mpt_pkg::word_t             point_z,
	output logic                       done,
	output mpt_pkg::word_t             moved_x,
	output mpt_pkg::word_t             moved_y,
	output mpt_pkg::word_t             moved_z,
	output logic                       overflow,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [mpt_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);
	import mpt_pkg::*;

	cfg_t  cfg;
	prep_t prep;
	logic  in_word;

	// word accepted on the point channel
	assign busy    = 1'b0;
	assign in_word = start && !busy;

	mpt_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	mpt_prep u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_valid (in_word),
		.px       (point_x),
		.py       (point_y),
		.pz       (point_z),
		.prep     (prep)
	);

	mpt_mix u_mix (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.prep     (prep),
		.done     (done),
		.moved_x  (moved_x),
		.moved_y  (moved_y),
		.moved_z  (moved_z),
		.overflow (overflow)
	);

	`MPT_ASSERT_IMP(a_done_from_start, done, $past(start, 5), "result without a point five cycles back")

endmodule
